FILE: sv/crc_frame_receiver_top_assert.svh
// ----------------------------------------------------------------------------
// crc_frame_receiver_top assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CRC_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CRC_FRAME_RECEIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CRCFR_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc_frame_receiver_top: implication check failed");
`define CRCFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc_frame_receiver_top: next-cycle check failed");
`else
`define CRCFR_ASSERT_IMPLIES(lbl, ante, cons)
`define CRCFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared constants, types and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crcfr_pkg;

    localparam int MAX_FRAME_BYTES = 16;
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W = $clog2(MAX_FRAME_BYTES - 6);
    localparam int REG_IDX_W = 2;

    localparam logic [7:0] HEADER_FIRST = 8'h77;
    localparam logic [7:0] HEADER_SECOND = 8'h99;
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [REG_IDX_W-1:0] REG_DEVICE_ADDR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_READ_OPCODE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_OPCODE = 2'd2;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_VALID    = 2'd1,
        ST_DISCARD  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_hdr_first;
        logic       is_hdr_second;
        logic       addr_ok;
        logic       is_read;
        logic       is_write;
    } rx_item_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/crcfr_front.sv
// ----------------------------------------------------------------------------
// crcfr_front
// Holds the configuration registers and tags each received byte with its
// header, address and opcode matches before it enters the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcfr_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [crcfr_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_data,
    input  logic                               in_valid,
    input  logic [7:0]                         rx_byte,
    input  logic                               q_ready,
    output logic                               in_ready,
    output logic                               push,
    output crcfr_pkg::rx_item_t                item
);

    logic [7:0] dev_addr_reg;
    logic [7:0] rd_op_reg;
    logic [7:0] wr_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 8'd1;
            rd_op_reg    <= 8'd3;
            wr_op_reg    <= 8'd16;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                crcfr_pkg::REG_DEVICE_ADDR:  dev_addr_reg <= cfg_data;
                crcfr_pkg::REG_READ_OPCODE:  rd_op_reg    <= cfg_data;
                crcfr_pkg::REG_WRITE_OPCODE: wr_op_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

    always_comb
    begin
        item.data          = rx_byte;
        item.is_hdr_first  = (rx_byte == crcfr_pkg::HEADER_FIRST);
        item.is_hdr_second = (rx_byte == crcfr_pkg::HEADER_SECOND);
        item.addr_ok       = (rx_byte == dev_addr_reg) || (rx_byte == crcfr_pkg::BROADCAST_ADDR);
        item.is_read       = (rx_byte == rd_op_reg);
        item.is_write      = (rx_byte == wr_op_reg);
    end

endmodule

FILE: sv/crcfr_queue.sv
// ----------------------------------------------------------------------------
// crcfr_queue
// Two-entry queue of tagged bytes between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcfr_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  crcfr_pkg::rx_item_t push_item,
    output logic                q_ready,
    input  logic                pop,
    output logic                q_valid,
    output crcfr_pkg::rx_item_t q_item
);

    crcfr_pkg::rx_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/crcfr_back.sv
// ----------------------------------------------------------------------------
// crcfr_back
// Frame parser: tracks the position in the frame, runs the CRC, decides the
// status of each byte and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcfr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  crcfr_pkg::rx_item_t q_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          byte_value,
    output logic [3:0]          byte_position,
    output logic [1:0]          frame_status,
    output logic                write_request,
    output logic [3:0]          payload_bytes
);

    localparam int CW = crcfr_pkg::CNT_W;
    localparam int LW = crcfr_pkg::LEN_W;
    localparam logic [CW-1:0] POS_HDR_FIRST  = CW'(0);
    localparam logic [CW-1:0] POS_HDR_SECOND = CW'(1);
    localparam logic [CW-1:0] POS_ADDRESS    = CW'(2);
    localparam logic [CW-1:0] POS_FUNCTION   = CW'(3);
    localparam logic [CW-1:0] POS_SUBADDR    = CW'(4);
    localparam logic [CW-1:0] POS_LENGTH     = CW'(5);
    localparam logic [CW-1:0] POS_PAYLOAD    = CW'(6);
    localparam logic [8:0]    MAX_LEN_SUM    = 9'(crcfr_pkg::MAX_FRAME_BYTES);

    logic [CW-1:0] cnt_reg,    cnt_next;
    logic          is_wr_reg,  is_wr_next;
    logic [LW-1:0] len_reg,    len_next;
    logic [15:0]   crc_reg,    crc_next;
    logic          lo_ok_reg,  lo_ok_next;

    logic          out_valid_reg;
    logic [7:0]    byte_value_reg;
    logic [3:0]    byte_position_reg;
    logic [1:0]    frame_status_reg;
    logic          write_request_reg;
    logic [3:0]    payload_bytes_reg;

    crcfr_pkg::status_t status;
    logic [15:0]   crc_fed;
    logic [CW-1:0] crc_lo_pos;
    logic [8:0]    len_sum;

    assign pop     = q_valid && (!out_valid_reg || out_ready);
    assign crc_fed = crcfr_pkg::crc_feed(crc_reg, q_item.data);
    assign crc_lo_pos = POS_PAYLOAD + CW'(len_reg);
    assign len_sum = {1'b0, q_item.data} + 9'd8;

    always_comb
    begin
        status     = crcfr_pkg::ST_CONTINUE;
        is_wr_next = is_wr_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        lo_ok_next = lo_ok_reg;
        if (cnt_reg == POS_HDR_FIRST)
        begin
            is_wr_next = 1'b0;
            len_next   = '0;
            crc_next   = crcfr_pkg::CRC_INIT;
            lo_ok_next = 1'b0;
            if (!q_item.is_hdr_first)
            begin
                status = crcfr_pkg::ST_DISCARD;
            end
        end
        else if (cnt_reg == POS_HDR_SECOND)
        begin
            if (!q_item.is_hdr_second)
            begin
                status = crcfr_pkg::ST_DISCARD;
            end
        end
        else if (cnt_reg == POS_ADDRESS)
        begin
            if (!q_item.addr_ok)
            begin
                status = crcfr_pkg::ST_DISCARD;
            end
            else
            begin
                crc_next = crc_fed;
            end
        end
        else if (cnt_reg == POS_FUNCTION)
        begin
            if (q_item.is_read)
            begin
                is_wr_next = 1'b0;
                crc_next   = crc_fed;
            end
            else if (q_item.is_write)
            begin
                is_wr_next = 1'b1;
                crc_next   = crc_fed;
            end
            else
            begin
                is_wr_next = 1'b0;
                status     = crcfr_pkg::ST_DISCARD;
            end
        end
        else if (cnt_reg == POS_SUBADDR)
        begin
            crc_next = crc_fed;
        end
        else if (cnt_reg == POS_LENGTH)
        begin
            if (is_wr_reg)
            begin
                if (len_sum > MAX_LEN_SUM)
                begin
                    status = crcfr_pkg::ST_DISCARD;
                end
                else
                begin
                    len_next = LW'(q_item.data);
                    crc_next = crc_fed;
                end
            end
            else
            begin
                len_next = '0;
                crc_next = crc_fed;
            end
        end
        else if (cnt_reg < crc_lo_pos)
        begin
            crc_next = crc_fed;
        end
        else if (cnt_reg == crc_lo_pos)
        begin
            lo_ok_next = (q_item.data == crc_reg[7:0]);
        end
        else
        begin
            if (lo_ok_reg && (q_item.data == crc_reg[15:8]))
            begin
                status = crcfr_pkg::ST_VALID;
            end
            else
            begin
                status = crcfr_pkg::ST_DISCARD;
            end
        end
        cnt_next = cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            is_wr_reg     <= 1'b0;
            len_reg       <= '0;
            crc_reg       <= crcfr_pkg::CRC_INIT;
            lo_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                if (status == crcfr_pkg::ST_CONTINUE)
                begin
                    cnt_reg   <= cnt_next;
                    is_wr_reg <= is_wr_next;
                    len_reg   <= len_next;
                    crc_reg   <= crc_next;
                    lo_ok_reg <= lo_ok_next;
                end
                else
                begin
                    cnt_reg   <= '0;
                    is_wr_reg <= 1'b0;
                    len_reg   <= '0;
                    crc_reg   <= crcfr_pkg::CRC_INIT;
                    lo_ok_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_value_reg    <= q_item.data;
            byte_position_reg <= 4'(cnt_reg);
            frame_status_reg  <= status;
            write_request_reg <= is_wr_next;
            payload_bytes_reg <= 4'(len_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_value    = byte_value_reg;
    assign byte_position = byte_position_reg;
    assign frame_status  = frame_status_reg;
    assign write_request = write_request_reg;
    assign payload_bytes = payload_bytes_reg;

endmodule

FILE: sv/crc_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// crc_frame_receiver_top
// Byte-serial request frame checker with CRC-16/MODBUS verification.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     rx_byte
//   out      output     out_valid / out_ready   byte_value, byte_position,
//                                               frame_status, write_request,
//                                               payload_bytes
//   cfg      input      cfg_wr_en               cfg_index, cfg_data
//
// One byte per cycle sustained while out_ready accepts results; each result
// passes through the queue register and then the output register.
// The two-entry queue lets input transactions continue while a result waits.
// Reset clears the frame state and loads the default configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "crc_frame_receiver_top_assert.svh"

module crc_frame_receiver_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [crcfr_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      byte_value,
    output logic [3:0]                      byte_position,
    output logic [1:0]                      frame_status,
    output logic                            write_request,
    output logic [3:0]                      payload_bytes
);

    logic                push;
    logic                pop;
    logic                q_ready;
    logic                q_valid;
    crcfr_pkg::rx_item_t push_item;
    crcfr_pkg::rx_item_t q_item;

    crcfr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .rx_byte   (rx_byte),
        .q_ready   (q_ready),
        .in_ready  (in_ready),
        .push      (push),
        .item      (push_item)
    );

    crcfr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    crcfr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_value    (byte_value),
        .byte_position (byte_position),
        .frame_status  (frame_status),
        .write_request (write_request),
        .payload_bytes (payload_bytes)
    );

    `CRCFR_ASSERT_IMPLIES(a_full_queue_has_data, !in_ready, q_valid)
    `CRCFR_ASSERT_NEXT(a_pop_gives_result, pop, out_valid)
    `CRCFR_ASSERT_IMPLIES(a_read_has_no_payload, out_valid && !write_request, payload_bytes == 4'd0)

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: crc_frame_receiver_top testbench
// Streams well-formed and broken request frames with random content under
// several address and opcode settings, with random idling on both sides and
// one long output stall. A scoreboard predicts every echoed byte, including
// its position, frame status, write flag and payload count, and compares
// each output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 700000;
    localparam int PHASE_ITEMS = 250;
    localparam int STALL_AFTER_RESULTS = 400;
    localparam int STALL_CYCLES = 120;
    localparam logic [crcfr_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        FAULT_NONE,
        FAULT_HEADER,
        FAULT_ADDRESS,
        FAULT_OPCODE,
        FAULT_LENGTH,
        FAULT_CRC_LOW,
        FAULT_CRC_HIGH
    } fault_t;

    typedef struct {
        logic [7:0]         value;
        logic [3:0]         position;
        crcfr_pkg::status_t status;
        logic               wr;
        logic [3:0]         plen;
    } echo_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ crcfr_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    class frame_scoreboard;
        logic [7:0]  own_addr;
        logic [7:0]  rd_op;
        logic [7:0]  wr_op;
        logic [7:0]  frame_pos;
        logic        is_write;
        logic [7:0]  plen;
        logic [15:0] crc;
        logic        lo_ok;
        echo_t       echo_q[$];
        int          errors;
        int          checked;

        function new();
            own_addr = 8'd1;
            rd_op = 8'd3;
            wr_op = 8'd16;
            errors = 0;
            checked = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            frame_pos = 8'd0;
            is_write = 1'b0;
            plen = 8'd0;
            crc = crcfr_pkg::CRC_INIT;
            lo_ok = 1'b0;
        endfunction

        function void write_reg(input logic [crcfr_pkg::REG_IDX_W-1:0] idx,
                                input logic [7:0] data);
            if (idx == crcfr_pkg::REG_DEVICE_ADDR)
                own_addr = data;
            else if (idx == crcfr_pkg::REG_READ_OPCODE)
                rd_op = data;
            else if (idx == crcfr_pkg::REG_WRITE_OPCODE)
                wr_op = data;
        endfunction

        function int pending();
            return echo_q.size();
        endfunction

        function void note_byte(input logic [7:0] b);
            echo_t              e;
            crcfr_pkg::status_t st;
            logic [7:0]         pos;
            int                 lo_at;
            pos = frame_pos;
            st = crcfr_pkg::ST_CONTINUE;
            if (pos == 0)
            begin
                clear_frame();
                if (b != crcfr_pkg::HEADER_FIRST)
                    st = crcfr_pkg::ST_DISCARD;
            end
            else if (pos == 1)
            begin
                if (b != crcfr_pkg::HEADER_SECOND)
                    st = crcfr_pkg::ST_DISCARD;
            end
            else if (pos == 2)
            begin
                if (b != own_addr && b != crcfr_pkg::BROADCAST_ADDR)
                    st = crcfr_pkg::ST_DISCARD;
                else
                    crc = crc16_update(crc, b);
            end
            else if (pos == 3)
            begin
                if (b == rd_op)
                    is_write = 1'b0;
                else if (b == wr_op)
                    is_write = 1'b1;
                else
                begin
                    is_write = 1'b0;
                    st = crcfr_pkg::ST_DISCARD;
                end
                if (st == crcfr_pkg::ST_CONTINUE)
                    crc = crc16_update(crc, b);
            end
            else if (pos == 4)
            begin
                crc = crc16_update(crc, b);
            end
            else if (pos == 5)
            begin
                if (is_write)
                begin
                    if (int'(b) + 8 > crcfr_pkg::MAX_FRAME_BYTES)
                        st = crcfr_pkg::ST_DISCARD;
                    else
                        plen = b;
                end
                else
                begin
                    plen = 8'd0;
                end
                if (st == crcfr_pkg::ST_CONTINUE)
                    crc = crc16_update(crc, b);
            end
            else
            begin
                lo_at = 6 + int'(plen);
                if (int'(pos) < lo_at)
                    crc = crc16_update(crc, b);
                else if (int'(pos) == lo_at)
                    lo_ok = (b == crc[7:0]);
                else if (lo_ok && b == crc[15:8])
                    st = crcfr_pkg::ST_VALID;
                else
                    st = crcfr_pkg::ST_DISCARD;
            end
            e.value = b;
            e.position = pos[3:0];
            e.status = st;
            e.wr = is_write;
            e.plen = plen[3:0];
            echo_q.push_back(e);
            if (st == crcfr_pkg::ST_CONTINUE)
                frame_pos = pos + 8'd1;
            else
                clear_frame();
        endfunction

        function void check_echo(input logic [7:0] v, input logic [3:0] p, input logic [1:0] s,
                                 input logic w, input logic [3:0] n);
            echo_t e;
            checked++;
            if (echo_q.size() == 0)
            begin
                $error("output transaction with nothing expected: byte_value %0h", v);
                errors++;
                return;
            end
            e = echo_q.pop_front();
            if (v !== e.value)
            begin
                $error("byte_value: expected %0h, actual %0h", e.value, v);
                errors++;
            end
            if (p !== e.position)
            begin
                $error("byte_position: expected %0d, actual %0d", e.position, p);
                errors++;
            end
            if (s !== e.status)
            begin
                $error("frame_status: expected %0d, actual %0d", e.status, s);
                errors++;
            end
            if (w !== e.wr)
            begin
                $error("write_request: expected %0d, actual %0d", e.wr, w);
                errors++;
            end
            if (n !== e.plen)
            begin
                $error("payload_bytes: expected %0d, actual %0d", e.plen, n);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [crcfr_pkg::REG_IDX_W-1:0] cfg_index;
    logic [7:0]                      cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [7:0]                      rx_byte;
    logic                            out_valid;
    logic                            out_ready;
    logic [7:0]                      byte_value;
    logic [3:0]                      byte_position;
    logic [1:0]                      frame_status;
    logic                            write_request;
    logic [3:0]                      payload_bytes;

    frame_scoreboard sb = new();
    int  cycle_count = 0;
    int  items_sent = 0;
    bit  steady = 1'b0;
    bit  stall_active = 1'b0;
    bit  stall_done = 1'b0;

    crc_frame_receiver_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_value    (byte_value),
        .byte_position (byte_position),
        .frame_status  (frame_status),
        .write_request (write_request),
        .payload_bytes (payload_bytes)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("crc_frame_receiver_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(rx_byte);
            if (out_valid && out_ready)
                sb.check_echo(byte_value, byte_position, frame_status, write_request,
                              payload_bytes);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!stall_done && sb.checked >= STALL_AFTER_RESULTS)
            begin
                stall_active = 1'b1;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_active = 1'b0;
                stall_done = 1'b1;
            end
            gap = steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (steady || stall_active) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame(input bit write_kind, input logic [7:0] addr,
                              input logic [7:0] len, input fault_t fault);
        logic [7:0]  frame_bytes[$];
        logic [7:0]  op;
        logic [15:0] c;
        int          payload_n;
        op = write_kind ? sb.wr_op : sb.rd_op;
        if (fault == FAULT_ADDRESS)
        begin
            do
                addr = 8'($urandom);
            while (addr == sb.own_addr || addr == crcfr_pkg::BROADCAST_ADDR);
        end
        if (fault == FAULT_OPCODE)
        begin
            do
                op = 8'($urandom);
            while (op == sb.rd_op || op == sb.wr_op);
        end
        frame_bytes.push_back(crcfr_pkg::HEADER_FIRST);
        frame_bytes.push_back(crcfr_pkg::HEADER_SECOND);
        frame_bytes.push_back(addr);
        frame_bytes.push_back(op);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(len);
        if (fault != FAULT_LENGTH)
        begin
            payload_n = write_kind ? int'(len) : 0;
            for (int k = 0; k < payload_n; k++)
                frame_bytes.push_back(8'($urandom));
            c = crcfr_pkg::CRC_INIT;
            for (int k = 2; k < frame_bytes.size(); k++)
                c = crc16_update(c, frame_bytes[k]);
            frame_bytes.push_back(c[7:0]);
            frame_bytes.push_back(c[15:8]);
            if (fault == FAULT_HEADER)
                frame_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            else if (fault == FAULT_CRC_LOW)
                frame_bytes[frame_bytes.size() - 2] ^= 8'($urandom_range(1, 255));
            else if (fault == FAULT_CRC_HIGH)
                frame_bytes[frame_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
        end
        foreach (frame_bytes[k])
            send_byte(frame_bytes[k]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] addr, input logic [7:0] rd,
                                input logic [7:0] wr);
        logic [crcfr_pkg::REG_IDX_W-1:0] idx[4];
        logic [7:0]                      val[4];
        idx = '{crcfr_pkg::REG_DEVICE_ADDR, crcfr_pkg::REG_READ_OPCODE,
                crcfr_pkg::REG_WRITE_OPCODE, REG_UNUSED};
        val = '{addr, rd, wr, 8'($urandom)};
        for (int k = 0; k < 4; k++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            @(posedge clk);
            sb.write_reg(idx[k], val[k]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_traffic(input int count);
        int         target;
        int         r;
        bit         wk;
        logic [7:0] addr;
        logic [7:0] len;
        fault_t     fault;
        target = items_sent + count;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            wk = 1'($urandom_range(0, 1));
            addr = $urandom_range(0, 1) ? sb.own_addr : crcfr_pkg::BROADCAST_ADDR;
            len = wk ? 8'($urandom_range(0, crcfr_pkg::MAX_FRAME_BYTES - 8)) : 8'($urandom);
            if (r < 70)
            begin
                send_frame(wk, addr, len, FAULT_NONE);
            end
            else if (r < 90)
            begin
                fault = fault_t'($urandom_range(FAULT_HEADER, FAULT_CRC_HIGH));
                if (fault == FAULT_LENGTH)
                begin
                    wk = 1'b1;
                    len = $urandom_range(0, 1)
                        ? 8'(crcfr_pkg::MAX_FRAME_BYTES - 7)
                        : 8'($urandom_range(crcfr_pkg::MAX_FRAME_BYTES - 7, 255));
                end
                send_frame(wk, addr, len, fault);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [7:0] op;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        rx_byte = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset configuration.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(1'b0, sb.own_addr, 8'hFF, FAULT_NONE);
        send_frame(1'b1, crcfr_pkg::BROADCAST_ADDR, 8'd1, FAULT_CRC_HIGH);
        send_frame(1'b1, sb.own_addr, 8'hFF, FAULT_LENGTH);
        random_traffic(PHASE_ITEMS);
        drain();

        apply_config(8'h00, 8'h00, 8'hFF);
        random_traffic(PHASE_ITEMS);
        drain();

        apply_config(8'hFF, 8'hFF, 8'h00);
        random_traffic(PHASE_ITEMS);
        drain();

        op = 8'($urandom);
        apply_config(8'($urandom), op, op);
        random_traffic(PHASE_ITEMS);
        drain();

        steady = 1'b1;
        apply_config(8'($urandom), 8'($urandom), 8'($urandom));
        random_traffic(PHASE_ITEMS);
        drain();
        steady = 1'b0;

        apply_config(8'($urandom), 8'($urandom), 8'($urandom));
        random_traffic(PHASE_ITEMS);
        drain();

        if (sb.errors == 0)
            $display("crc_frame_receiver_top test passed");
        else
            $display("crc_frame_receiver_top test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/crcfr_pkg.sv
sv/crcfr_front.sv
sv/crcfr_queue.sv
sv/crcfr_back.sv
sv/crc_frame_receiver_top.sv
tb/tb_top.sv
